// ===== sv/tonu_pkg.sv =====
package tonu_pkg;

	localparam logic [7:0] IAC     = 8'd255;
	localparam logic [7:0] SB      = 8'd250;
	localparam logic [7:0] WILL    = 8'd251;
	localparam logic [7:0] WONT    = 8'd252;
	localparam logic [7:0] DO      = 8'd253;
	localparam logic [7:0] DONT    = 8'd254;
	localparam logic [7:0] SE      = 8'd240;
	localparam logic [7:0] SEND    = 8'd1;
	localparam logic [7:0] IS      = 8'd0;
	localparam logic [7:0] OPT_RST = 8'd3;

	typedef enum logic [2:0] {
		PH_TEXT    = 3'd0,
		PH_IAC     = 3'd1,
		PH_OPT     = 3'd2,
		PH_SBOPT   = 3'd3,
		PH_SBFIRST = 3'd4,
		PH_SBREST  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		DK_TEXT = 2'd0,
		DK_NEG  = 2'd1,
		DK_SUB  = 2'd2
	} desc_kind_t;

	localparam logic KIND_TEXT  = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	localparam logic [2:0] NEG_LAST_IDX = 3'd2;
	localparam logic [2:0] SUB_LAST_IDX = 3'd5;

	typedef struct packed {
		desc_kind_t kind;
		logic [7:0] data;
		logic [7:0] cmd;
		logic       eob;
	} desc_t;

endpackage

// ===== sv/tonu_parser.sv =====
module tonu_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       rx_byte,
	input  logic             eob,
	input  logic [7:0]       accepted_option,
	output logic             push,
	output tonu_pkg::desc_t  desc
);
	import tonu_pkg::*;

	phase_t     phase_q, phase_d;
	logic [2:0] held_cmd_q, held_cmd_d;
	logic [7:0] held_opt_q, held_opt_d;
	logic       send_req_q, send_req_d;

	logic       do_idle;
	logic [7:0] cmd_full;
	logic       agree;
	logic [7:0] rep;

	assign cmd_full = {5'b11111, held_cmd_q};
	assign agree    = (rx_byte == accepted_option);

	always_comb begin
		case (cmd_full)
			DO:      rep = agree ? WILL : WONT;
			DONT:    rep = WONT;
			WILL:    rep = agree ? DO : DONT;
			default: rep = DONT;
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		held_cmd_d = held_cmd_q;
		held_opt_d = held_opt_q;
		send_req_d = send_req_q;
		do_idle    = 1'b0;
		push       = 1'b0;
		desc.kind  = DK_TEXT;
		desc.data  = rx_byte;
		desc.cmd   = rep;
		desc.eob   = eob;
		case (phase_q)
			PH_IAC: begin
				if (rx_byte >= WILL && rx_byte <= DONT) begin
					held_cmd_d = rx_byte[2:0];
					phase_d    = PH_OPT;
				end else if (rx_byte == SB) begin
					phase_d = PH_SBOPT;
				end else begin
					do_idle = 1'b1;
				end
			end
			PH_OPT: begin
				push      = 1'b1;
				desc.kind = DK_NEG;
				phase_d   = PH_TEXT;
			end
			PH_SBOPT: begin
				if (rx_byte == SE) begin
					phase_d = PH_TEXT;
				end else begin
					held_opt_d = rx_byte;
					phase_d    = PH_SBFIRST;
				end
			end
			PH_SBFIRST: begin
				if (rx_byte == SE) begin
					phase_d = PH_TEXT;
				end else begin
					send_req_d = (rx_byte == SEND);
					phase_d    = PH_SBREST;
				end
			end
			PH_SBREST: begin
				if (rx_byte == SE) begin
					phase_d = PH_TEXT;
					if (send_req_q && held_opt_q == accepted_option) begin
						push      = 1'b1;
						desc.kind = DK_SUB;
						desc.data = held_opt_q;
					end
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase
		if (do_idle) begin
			if (rx_byte == IAC) begin
				phase_d = PH_IAC;
			end else begin
				phase_d   = PH_TEXT;
				push      = 1'b1;
				desc.kind = DK_TEXT;
			end
		end
		push = push & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TEXT;
			held_cmd_q <= 3'd0;
			held_opt_q <= 8'd0;
			send_req_q <= 1'b0;
		end else if (accept) begin
			phase_q    <= phase_d;
			held_cmd_q <= held_cmd_d;
			held_opt_q <= held_opt_d;
			send_req_q <= send_req_d;
		end
	end

endmodule

// ===== sv/tonu_reply_queue.sv =====
module tonu_reply_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tonu_pkg::desc_t  desc_in,
	output logic             full,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);
	import tonu_pkg::*;

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic [2:0] idx_q;
	desc_t      head;
	logic       final_byte;
	logic       pop;

	assign head     = mem_q[rd_ptr_q];
	assign full     = (count_q == 2'd2);
	assign m_tvalid = (count_q != 2'd0);

	always_comb begin
		m_tuser    = KIND_REPLY;
		m_tlast    = 1'b0;
		m_tdata    = IAC;
		final_byte = 1'b0;
		case (head.kind)
			DK_TEXT: begin
				m_tuser    = KIND_TEXT;
				m_tdata    = head.data;
				m_tlast    = head.eob;
				final_byte = 1'b1;
			end
			DK_NEG: begin
				case (idx_q)
					3'd0:    m_tdata = IAC;
					3'd1:    m_tdata = head.cmd;
					default: m_tdata = head.data;
				endcase
				final_byte = (idx_q == NEG_LAST_IDX);
				m_tlast    = final_byte;
			end
			default: begin
				case (idx_q)
					3'd0:    m_tdata = IAC;
					3'd1:    m_tdata = SB;
					3'd2:    m_tdata = head.data;
					3'd3:    m_tdata = IS;
					3'd4:    m_tdata = IAC;
					default: m_tdata = SE;
				endcase
				final_byte = (idx_q == SUB_LAST_IDX);
				m_tlast    = final_byte;
			end
		endcase
	end

	assign pop = m_tvalid & m_tready & final_byte;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= desc_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			idx_q    <= 3'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
				idx_q    <= 3'd0;
			end else if (m_tvalid && m_tready) begin
				idx_q <= idx_q + 3'd1;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("reply queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("descriptor pushed into a full queue");
	a_idx_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> idx_q == 3'd0)
		else $error("byte index not cleared while queue empty");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (idx_q <= SUB_LAST_IDX)
			&& (head.kind != DK_TEXT || idx_q == 3'd0)
			&& (head.kind != DK_NEG || idx_q <= NEG_LAST_IDX))
		else $error("byte index beyond reply length");
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> m_tvalid)
		else $error("pushed descriptor not presented");
`endif

endmodule

// ===== sv/telnet_option_negotiator_unit.sv =====
// Channel   Direction  tdata          tuser  tlast
// s_*       in         rx_byte[7:0]   -      end_of_buffer
// m_*       out        out_byte[7:0]  kind   last
// cfg_*     in         accepted_option[7:0] on cfg_wdata, written when cfg_we is high
//
// One received byte is taken per cycle; its results enter a two-entry reply queue.
// Text leaves as one byte, a WILL/WONT/DO/DONT reply as three bytes and a
// subnegotiation reply as six, one byte per output transfer from the queue head.
// Input is stalled only while both queue entries are occupied.
// Reset clears the parser phase, held command and option, and the queue.
module telnet_option_negotiator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tuser,   // [0] kind
	output logic       m_tlast,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	import tonu_pkg::*;

	logic [7:0] accepted_option_q;
	logic       accept;
	logic       push;
	logic       full;
	desc_t      desc;

	assign s_tready = !full;
	assign accept   = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_option_q <= OPT_RST;
		end else if (cfg_we) begin
			accepted_option_q <= cfg_wdata;
		end
	end

	tonu_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.rx_byte         (s_tdata),
		.eob             (s_tlast),
		.accepted_option (accepted_option_q),
		.push            (push),
		.desc            (desc)
	);

	tonu_reply_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.desc_in  (desc),
		.full     (full),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== sim/telnet_option_negotiator_unit_test.sv =====
module telnet_option_negotiator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tonu_pkg::*;

	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT = 60000;
	localparam int HOLD_AT = 80;
	localparam int HOLD_LEN = 90;

	typedef struct {
		logic [7:0] rx;
		logic       eob;
	} rx_item_t;

	typedef struct {
		logic       kind;
		logic [7:0] data;
		logic       last;
	} reply_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tuser;
	logic       m_tlast;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;

	rx_item_t    rx_pending[$];
	reply_beat_t replies_due[$];

	phase_t     phase = PH_TEXT;
	logic [2:0] held_cmd = 3'd0;
	logic [7:0] held_opt = 8'd0;
	logic       send_req = 1'b0;
	logic [7:0] agreed_opt = OPT_RST;

	int   items_queued = 0;
	int   items_in = 0;
	int   errors = 0;
	int   cycles = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   hold_left = 0;
	bit   held_once = 0;
	bit   idling = 1;
	logic s_took = 1'b0;
	logic m_took = 1'b0;

	telnet_option_negotiator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic void queue_beat(logic k, logic [7:0] d, logic l);
		reply_beat_t beat;
		beat.kind = k;
		beat.data = d;
		beat.last = l;
		replies_due.push_back(beat);
	endfunction

	function automatic void take_idle(logic [7:0] b, logic eob);
		if (b == IAC) begin
			phase = PH_IAC;
		end else begin
			phase = PH_TEXT;
			queue_beat(KIND_TEXT, b, eob);
		end
	endfunction

	function automatic void predict_replies(logic [7:0] b, logic eob);
		logic [7:0] cmd;
		logic [7:0] rep;
		logic       agree;
		case (phase)
			PH_IAC: begin
				if (b >= WILL && b <= DONT) begin
					held_cmd = b[2:0];
					phase = PH_OPT;
				end else if (b == SB) begin
					phase = PH_SBOPT;
				end else begin
					take_idle(b, eob);
				end
			end
			PH_OPT: begin
				cmd = {5'b11111, held_cmd};
				agree = (b == agreed_opt);
				if (cmd == DO)
					rep = agree ? WILL : WONT;
				else if (cmd == DONT)
					rep = WONT;
				else if (cmd == WILL)
					rep = agree ? DO : DONT;
				else
					rep = DONT;
				phase = PH_TEXT;
				queue_beat(KIND_REPLY, IAC, 1'b0);
				queue_beat(KIND_REPLY, rep, 1'b0);
				queue_beat(KIND_REPLY, b, 1'b1);
			end
			PH_SBOPT: begin
				if (b == SE) begin
					phase = PH_TEXT;
				end else begin
					held_opt = b;
					phase = PH_SBFIRST;
				end
			end
			PH_SBFIRST: begin
				if (b == SE) begin
					phase = PH_TEXT;
				end else begin
					send_req = (b == SEND);
					phase = PH_SBREST;
				end
			end
			PH_SBREST: begin
				if (b == SE) begin
					phase = PH_TEXT;
					if (send_req && held_opt == agreed_opt) begin
						queue_beat(KIND_REPLY, IAC, 1'b0);
						queue_beat(KIND_REPLY, SB, 1'b0);
						queue_beat(KIND_REPLY, held_opt, 1'b0);
						queue_beat(KIND_REPLY, IS, 1'b0);
						queue_beat(KIND_REPLY, IAC, 1'b0);
						queue_beat(KIND_REPLY, SE, 1'b1);
					end
				end
			end
			default: begin
				take_idle(b, eob);
			end
		endcase
	endfunction

	// Transfers on both sides are taken at the rising edge.
	always @(posedge clk) begin
		reply_beat_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			s_took = arst_n && s_tvalid && s_tready;
			m_took = arst_n && m_tvalid && m_tready;
			if (s_took) begin
				predict_replies(s_tdata, s_tlast);
				items_in++;
			end
			if (m_took) begin
				if (replies_due.size() == 0) begin
					$error("unexpected result: out_byte %0d kind %0d last %0d",
						m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					want = replies_due.pop_front();
					if (m_tuser !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, m_tuser);
						errors++;
					end
					if (m_tdata !== want.data) begin
						$error("out_byte: expected %0d, got %0d", want.data, m_tdata);
						errors++;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_tlast);
						errors++;
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		rx_item_t cur;
		if (arst_n && (s_took || !s_tvalid)) begin
			if (s_took)
				send_gap = idling ? $urandom_range(0, 4) : 0;
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (rx_pending.size() > 0) begin
				cur = rx_pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= cur.rx;
				s_tlast <= cur.eob;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// The long hold-off lets the reply queue fill so that the input stalls.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_once && items_in >= HOLD_AT) begin
				held_once = 1;
				hold_left = HOLD_LEN;
			end
			if (m_took)
				recv_gap = idling ? $urandom_range(0, 4) : 0;
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic push_byte(logic [7:0] b, logic eob);
		rx_item_t item;
		item.rx = b;
		item.eob = eob;
		rx_pending.push_back(item);
		items_queued++;
	endtask

	function automatic logic rand_eob();
		return ($urandom_range(0, 4) == 0);
	endfunction

	function automatic logic [7:0] pick_option();
		return ($urandom_range(0, 1) == 0) ? agreed_opt : 8'($urandom_range(0, 255));
	endfunction

	task automatic push_random_seq();
		int         pick;
		int         n;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			push_byte(8'($urandom_range(0, 254)), rand_eob());
		end else if (pick < 55) begin
			push_byte(IAC, rand_eob());
			push_byte(8'($urandom_range(WILL, DONT)), rand_eob());
			push_byte(pick_option(), rand_eob());
		end else if (pick < 78) begin
			push_byte(IAC, rand_eob());
			push_byte(SB, rand_eob());
			push_byte(pick_option(), rand_eob());
			push_byte(($urandom_range(0, 9) < 6) ? SEND : 8'($urandom_range(0, 255)),
				rand_eob());
			n = $urandom_range(0, 2);
			repeat (n) begin
				b = 8'($urandom_range(0, 254));
				push_byte((b == SE) ? IAC : b, rand_eob());
			end
			push_byte(SE, rand_eob());
		end else if (pick < 88) begin
			push_byte(IAC, rand_eob());
			push_byte(8'($urandom_range(0, 255)), rand_eob());
		end else begin
			push_byte(8'($urandom_range(0, 255)), rand_eob());
		end
	endtask

	task automatic run_random(int count);
		int target;
		target = items_queued + count;
		while (items_queued < target)
			push_random_seq();
	endtask

	task automatic settle();
		while (items_in != items_queued || replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_option(logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		agreed_opt = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Text, agreed and refused commands, a doubled IAC, IAC before SE,
		// short subnegotiations and an IAC inside a SEND subnegotiation.
		push_byte(8'h00, 1'b0);
		push_byte(SE, 1'b1);
		push_byte(IAC, 1'b0); push_byte(DO, 1'b0); push_byte(8'd3, 1'b1);
		push_byte(IAC, 1'b1); push_byte(WONT, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(IAC, 1'b0); push_byte(IAC, 1'b0); push_byte(WILL, 1'b0);
		push_byte(8'd3, 1'b0);
		push_byte(IAC, 1'b0); push_byte(SE, 1'b1);
		push_byte(IAC, 1'b0); push_byte(SB, 1'b0); push_byte(SE, 1'b0);
		push_byte(IAC, 1'b0); push_byte(SB, 1'b0); push_byte(8'd3, 1'b0);
		push_byte(SE, 1'b0);
		push_byte(IAC, 1'b0); push_byte(SB, 1'b1); push_byte(8'd3, 1'b0);
		push_byte(SEND, 1'b0); push_byte(IAC, 1'b0); push_byte(SE, 1'b1);
		settle();

		write_option(8'd0);
		push_byte(IAC, 1'b0); push_byte(DONT, 1'b0); push_byte(8'd0, 1'b0);
		run_random(40);
		settle();

		idling = 0;
		write_option(8'hFF);
		run_random(45);
		settle();

		idling = 1;
		write_option(8'($urandom_range(0, 255)));
		run_random(40);
		settle();

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
